// ===== rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and types of the pose frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

   localparam logic [7:0]  HDR_A    = 8'h0d;
   localparam logic [7:0]  HDR_B    = 8'h0a;
   localparam logic [7:0]  ACK_A    = 8'h4f;
   localparam logic [7:0]  ACK_B    = 8'h4b;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   localparam logic EVT_POSE = 1'b0;
   localparam logic EVT_ACK  = 1'b1;

   typedef struct packed {
      logic        hit;
      logic        event_kind;
      logic [31:0] angle_bits;
      logic [31:0] xpos_bits;
      logic [31:0] ypos_bits;
   } pfd_event_type;

endpackage

`default_nettype wire

// ===== rtl/pfd_req_if.sv =====
// ----------------------------------------------------------------------------
// pfd_req_if
// Byte channel into the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfd_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ===== rtl/pfd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfd_rsp_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfd_rsp_if;

   logic        valid;
   logic        ready;
   logic        event_kind;
   logic [31:0] angle_bits;
   logic [31:0] xpos_bits;
   logic [31:0] ypos_bits;

   modport source (output valid, output event_kind, output angle_bits,
                   output xpos_bits, output ypos_bits, input ready);
   modport sink   (input valid, input event_kind, input angle_bits,
                   input xpos_bits, input ypos_bits, output ready);

endinterface

`default_nettype wire

// ===== rtl/pfd_parser.sv =====
// ----------------------------------------------------------------------------
// pfd_parser
// Frame state machine, payload store and pose word mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_parser
   import pfd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    rx_byte,
   input  wire logic          axis_mode,
   output pfd_event_type      evt
);

   localparam int IDX_W = $clog2(PAYLOAD_BYTES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_PAY  = 3'd2;
   localparam logic [2:0] PH_TR1  = 3'd3;
   localparam logic [2:0] PH_TR2  = 3'd4;
   localparam logic [2:0] PH_ACK  = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             wr_en;
   logic [7:0]       payload_ff [PAYLOAD_BYTES];

   logic [31:0] w0, w3, w4;

   assign w0 = {payload_ff[3],  payload_ff[2],  payload_ff[1],  payload_ff[0]};
   assign w3 = {payload_ff[15], payload_ff[14], payload_ff[13], payload_ff[12]};
   assign w4 = {payload_ff[19], payload_ff[18], payload_ff[17], payload_ff[16]};

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      wr_en    = 1'b0;
      evt      = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == HDR_A) begin
               phase_in = PH_HDR;
            end else if (rx_byte == ACK_A) begin
               phase_in = PH_ACK;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_HDR: begin
            if (rx_byte == HDR_B) begin
               idx_in   = '0;
               phase_in = PH_PAY;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_PAY: begin
            wr_en = 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               phase_in = PH_TR1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         PH_TR1: begin
            phase_in = (rx_byte == HDR_B) ? PH_TR2 : PH_IDLE;
         end
         PH_TR2: begin
            phase_in = PH_IDLE;
            if (rx_byte == HDR_A) begin
               evt.hit        = 1'b1;
               evt.event_kind = EVT_POSE;
               if (axis_mode) begin
                  evt.angle_bits = w0 ^ SIGN_BIT;
                  evt.xpos_bits  = w4;
                  evt.ypos_bits  = w3 ^ SIGN_BIT;
               end else begin
                  evt.angle_bits = w0;
                  evt.xpos_bits  = w3;
                  evt.ypos_bits  = w4;
               end
            end
         end
         PH_ACK: begin
            phase_in = PH_IDLE;
            if (rx_byte == ACK_B) begin
               evt.hit        = 1'b1;
               evt.event_kind = EVT_ACK;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         payload_ff[idx_ff] <= rx_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// pfd_out_reg
// Result register driving the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_out_reg
   import pfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire pfd_event_type evt,
   output logic               free,
   pfd_rsp_if.source          rsp_bus
);

   logic          valid_ff;
   pfd_event_type data_ff;

   assign free = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= evt;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.event_kind = data_ff.event_kind;
   assign rsp_bus.angle_bits = data_ff.angle_bits;
   assign rsp_bus.xpos_bits  = data_ff.xpos_bits;
   assign rsp_bus.ypos_bits  = data_ff.ypos_bits;

endmodule

`default_nettype wire

// ===== rtl/pose_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// pose_frame_deframer
// Finds 0d 0a <payload> 0a 0d pose frames and OK acknowledges in a byte stream.
// ----------------------------------------------------------------------------
// Result path: the closing byte is registered in the input stage, then its
// result in the result register. Throughput: one byte per cycle while the
// result register is free, set by the single-step frame state machine.
// Reset: synchronous; clears phase, byte count, mode and both valid flags.
// Payload bytes hold no reset value; only written bytes are ever read.
`default_nettype none

module pose_frame_deframer
   import pfd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 24
) (
   input  wire logic clock,
   input  wire logic reset,
   pfd_req_if.sink   req_bus,
   pfd_rsp_if.source rsp_bus,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);

   logic          stage_valid_ff;
   logic [7:0]    stage_byte_ff;
   logic          axis_mode_ff;
   logic          out_free;
   logic          advance;
   pfd_event_type evt;

   assign advance       = stage_valid_ff && out_free;
   assign req_bus.ready = !stage_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stage_byte_ff <= req_bus.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         axis_mode_ff <= csr_wr_data;
      end
   end

   pfd_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (stage_byte_ff),
      .axis_mode (axis_mode_ff),
      .evt       (evt)
   );

   pfd_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && evt.hit),
      .evt     (evt),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.event_kind == EVT_ACK |->
         rsp_bus.angle_bits == 32'd0 && rsp_bus.xpos_bits == 32'd0 &&
         rsp_bus.ypos_bits == 32'd0)
      else $error("ack item carries nonzero data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !stage_valid_ff)
      else $error("valid set right after reset");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !advance |=> stage_valid_ff && $stable(stage_byte_ff))
      else $error("stalled input stage lost its byte");

   a_full_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready && stage_valid_ff |-> !req_bus.ready)
      else $error("byte taken while both stages blocked");

endmodule

`default_nettype wire

// ===== tb/pfd_frame_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_frame_checker
// Watches the byte and result channels of the pose frame deframer. It tracks
// the frame search and the axis mode on its own, queues the expected pose and
// acknowledge results, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module pfd_frame_checker
   import pfd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 24
) (
   input  logic clock,
   input  logic reset,
   pfd_req_if   req_mon,
   pfd_rsp_if   rsp_mon,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   output int   fail_count,
   output int   pending,
   output int   pose_count,
   output int   ack_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_PAYLOAD,
      PH_TRAIL_A,
      PH_TRAIL_B,
      PH_AFTER_O
   } deframe_phase_type;

   typedef struct packed {
      logic        event_kind;
      logic [31:0] angle_bits;
      logic [31:0] xpos_bits;
      logic [31:0] ypos_bits;
   } pose_result_type;

   deframe_phase_type phase      = PH_IDLE;
   int unsigned       body_count = 0;
   logic [7:0]        body [PAYLOAD_BYTES];
   logic              axis_mode  = 1'b0;
   pose_result_type   expected_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      pose_count = 0;
      ack_count  = 0;
   end

   function automatic logic [31:0] body_word(int w);
      return {body[4*w+3], body[4*w+2], body[4*w+1], body[4*w]};
   endfunction

   task automatic deframe(input logic [7:0] rx);
      pose_result_type res;
      res = '0;
      case (phase)
         PH_IDLE: begin
            if (rx == HDR_A) phase = PH_HDR;
            else if (rx == ACK_A) phase = PH_AFTER_O;
         end
         PH_HDR: begin
            if (rx == HDR_B) begin
               body_count = 0;
               phase      = PH_PAYLOAD;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_PAYLOAD: begin
            body[body_count] = rx;
            body_count++;
            if (body_count == PAYLOAD_BYTES) phase = PH_TRAIL_A;
         end
         PH_TRAIL_A: begin
            phase = (rx == HDR_B) ? PH_TRAIL_B : PH_IDLE;
         end
         PH_TRAIL_B: begin
            if (rx == HDR_A) begin
               res.event_kind = EVT_POSE;
               if (axis_mode) begin
                  res.angle_bits = body_word(0) ^ SIGN_BIT;
                  res.xpos_bits  = body_word(4);
                  res.ypos_bits  = body_word(3) ^ SIGN_BIT;
               end else begin
                  res.angle_bits = body_word(0);
                  res.xpos_bits  = body_word(3);
                  res.ypos_bits  = body_word(4);
               end
               expected_q.push_back(res);
            end
            phase = PH_IDLE;
         end
         PH_AFTER_O: begin
            if (rx == ACK_B) begin
               res.event_kind = EVT_ACK;
               expected_q.push_back(res);
            end
            phase = PH_IDLE;
         end
         default: begin
            phase = PH_IDLE;
         end
      endcase
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_result();
      pose_result_type want;
      if (expected_q.size() == 0) begin
         $error("result with nothing pending: event_kind %0d angle %h x %h y %h",
                rsp_mon.event_kind, rsp_mon.angle_bits, rsp_mon.xpos_bits,
                rsp_mon.ypos_bits);
         fail_count++;
         return;
      end
      want = expected_q.pop_front();
      compare_field("event_kind", 32'(want.event_kind), 32'(rsp_mon.event_kind));
      compare_field("angle_bits", want.angle_bits, rsp_mon.angle_bits);
      compare_field("xpos_bits", want.xpos_bits, rsp_mon.xpos_bits);
      compare_field("ypos_bits", want.ypos_bits, rsp_mon.ypos_bits);
      if (want.event_kind == EVT_ACK) ack_count++;
      else pose_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_IDLE;
         body_count = 0;
         axis_mode  = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_wr_en === 1'b1) axis_mode = csr_wr_data;
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) deframe(req_mon.rx_byte);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_result();
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/tb_pose_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_pose_frame_deframer
// Byte stream stimulus for the pose frame deframer: a directed opening with
// acknowledges, broken headers and an edge-value frame, then random runs of
// mostly well-formed frames mixed with broken ones and noise, over several
// axis mode settings, with random idling on both channels and one long
// result stall. Prediction and checking sit in pfd_frame_checker.
// ----------------------------------------------------------------------------
module tb_pose_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   import pfd_pkg::*;

   localparam int          PAYLOAD_BYTES = 24;
   localparam int          CLK_PERIOD    = 20;
   localparam int          RESET_CYCLES  = 7;
   localparam int          RANDOM_ITEMS  = 1350;
   localparam int          MODE_PHASES   = 6;
   localparam int          DRAIN_CYCLES  = 4;
   localparam int          HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        csr_wr_en       = 1'b0;
   logic        csr_wr_data     = 1'b0;
   logic        hold_off_request = 1'b0;
   int          fail_count;
   int          pending;
   int          pose_count;
   int          ack_count;
   int unsigned items_sent      = 0;
   int unsigned mode_writes     = 0;
   int unsigned cycle_count     = 0;
   int          calm_left       = 0;
   logic [7:0]  frame_body [PAYLOAD_BYTES];

   pfd_req_if req_bus ();
   pfd_rsp_if rsp_bus ();

   pose_frame_deframer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   pfd_frame_checker #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .pose_count (pose_count),
      .ack_count  (ack_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_body_byte();
      case ($urandom_range(0, 9))
         0: return HDR_A;
         1: return HDR_B;
         2: return $urandom_range(0, 1) ? ACK_A : ACK_B;
         3: return $urandom_range(0, 1) ? 8'h00 : 8'hff;
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] rx);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 80);
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input logic [7:0] second, input logic [7:0] trail_a,
                             input logic [7:0] trail_b);
      push_byte(HDR_A);
      push_byte(second);
      for (int i = 0; i < PAYLOAD_BYTES; i++) push_byte(frame_body[i]);
      push_byte(trail_a);
      push_byte(trail_b);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_axis_mode(input logic mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_writes++;
   endtask

   task automatic run_random(input int unsigned target);
      int         pick;
      int         noise_len;
      logic [7:0] bad;
      while (items_sent < target) begin
         for (int i = 0; i < PAYLOAD_BYTES; i++) frame_body[i] = rand_body_byte();
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            send_frame(HDR_B, HDR_B, HDR_A);
         end else if (pick < 78) begin
            push_byte(ACK_A);
            push_byte(ACK_B);
         end else if (pick < 84) begin
            if ($urandom_range(0, 2) == 0) bad = HDR_A;
            else do bad = 8'($urandom()); while (bad == HDR_B);
            send_frame(bad, HDR_B, HDR_A);
         end else if (pick < 91) begin
            if ($urandom_range(0, 1) == 0) begin
               do bad = rand_body_byte(); while (bad == HDR_B);
               send_frame(HDR_B, bad, HDR_A);
            end else begin
               do bad = rand_body_byte(); while (bad == HDR_A);
               send_frame(HDR_B, HDR_B, bad);
            end
         end else if (pick < 95) begin
            do bad = rand_body_byte(); while (bad == ACK_B);
            push_byte(ACK_A);
            push_byte(bad);
         end else begin
            noise_len = $urandom_range(1, 6);
            repeat (noise_len) push_byte(rand_body_byte());
         end
      end
   endtask

   // result side: random ready pattern, one long hold-off on request
   initial begin
      int span;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            span = 1 + pick_gap();
            rsp_bus.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 8);
            rsp_bus.ready <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("** pose_frame_deframer: FAILED **");
      $finish;
   end

   initial begin
      int unsigned base;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_axis_mode(1'b0);

      push_byte(ACK_A);
      push_byte(ACK_B);
      push_byte(ACK_A);
      push_byte(HDR_A);
      push_byte(HDR_B);
      push_byte(HDR_A);
      push_byte(HDR_A);
      push_byte(HDR_B);
      push_byte(ACK_A);
      push_byte(ACK_A);
      push_byte(ACK_B);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         if (i < 4) begin
            frame_body[i] = 8'hff;
         end else if (i < 12 || (i >= 16 && i < 20)) begin
            case (i % 4)
               0: frame_body[i] = HDR_A;
               1: frame_body[i] = HDR_B;
               2: frame_body[i] = ACK_A;
               default: frame_body[i] = ACK_B;
            endcase
         end else if (i < 16) begin
            frame_body[i] = 8'h00;
         end else begin
            frame_body[i] = 8'h80 ^ 8'(i);
         end
      end
      send_frame(HDR_B, HDR_B, HDR_A);
      base = items_sent;

      for (int ph = 0; ph < MODE_PHASES; ph++) begin
         drain();
         if (ph == 0) write_axis_mode(1'b1);
         else if (ph == 1) write_axis_mode(1'b0);
         else write_axis_mode(1'($urandom_range(0, 1)));
         if (ph == 2) hold_off_request = 1'b1;
         run_random(base + RANDOM_ITEMS * (ph + 1) / MODE_PHASES);
      end
      drain();

      $display("Sent %0d bytes under %0d axis mode writes; checked %0d pose frames, %0d acks.",
               items_sent, mode_writes, pose_count, ack_count);
      $display("Included a %0d-cycle result stall with the byte channel still offering items.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("** pose_frame_deframer: PASSED **");
      end else begin
         $display("** pose_frame_deframer: FAILED **");
      end
      $finish;
   end

endmodule
